>>> src/dqpi_pkg.sv
`default_nettype none
package dqpi_pkg;

  // default datapath width, saturation point of every sum and product
  localparam int DATA_WIDTH_DEF = 32;

  // magnitude approximation coefficients, Q0.16
  localparam logic [15:0] MAG_BIG   = 16'd62941;
  localparam logic [15:0] MAG_SMALL = 16'd26070;

  // reset value of the vector limit register
  localparam logic [30:0] LIMIT_RESET = 31'd72090;

  // register indexes
  localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [2:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [2:0] REG_VOLT_LIMIT  = 3'd2;
  localparam logic [2:0] REG_VOLT_TO_MOD = 3'd3;
  localparam logic [2:0] REG_D_INDUCT    = 3'd4;
  localparam logic [2:0] REG_Q_INDUCT    = 3'd5;
  localparam logic [2:0] REG_ROTOR_FLUX  = 3'd6;
  localparam logic [2:0] REG_FF_ENABLE   = 3'd7;

  localparam int CFG_ADDR_W = 5;

  typedef struct packed {
    logic [31:0]        time_step;
    logic signed [31:0] d_ref;
    logic signed [31:0] q_ref;
    logic signed [31:0] d_meas;
    logic signed [31:0] q_meas;
    logic signed [31:0] elec_speed;
    logic               clear_integ;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] d_volt;
    logic signed [31:0] q_volt;
    logic               limited;
  } out_word_t;

endpackage
`default_nettype wire

>>> src/dqpi_if.sv
`default_nettype none
interface dqpi_in_if
  import dqpi_pkg::*;
();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dqpi_out_if
  import dqpi_pkg::*;
();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> src/dq_current_pi_controller_core.sv
`default_nettype none
// one word in, one word out; one word is worked on at a time
// products are formed one at a time on the radix-4 serial multiplier (7 products, 9 when
// limiting, 6 more with feedforward on); when limiting, each scaled axis is divided by the
// magnitude on the bit-serial divider before the integrators are updated
// the next word can be taken the cycle after the result is loaded into the output register
// reset (synchronous, rst_n low): registers to defaults, limit 72090, integrators zero
module dq_current_pi_controller_core
  import dqpi_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  dqpi_in_if.sink                in_ch,
  dqpi_out_if.source             out_ch,
  input  wire                    cfg_psel,
  input  wire                    cfg_penable,
  input  wire                    cfg_pwrite,
  input  wire [CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire [31:0]             cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  localparam int SAT_BITS = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_POST  = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;

  // product steps
  localparam logic [3:0] SP_FF_WLQ  = 4'd0;
  localparam logic [3:0] SP_FF_TIQ  = 4'd1;
  localparam logic [3:0] SP_FF_DV   = 4'd2;
  localparam logic [3:0] SP_FF_LDID = 4'd3;
  localparam logic [3:0] SP_FF_WF   = 4'd4;
  localparam logic [3:0] SP_FF_QV   = 4'd5;
  localparam logic [3:0] SP_PI_D    = 4'd6;
  localparam logic [3:0] SP_PI_Q    = 4'd7;
  localparam logic [3:0] SP_MAG_BIG = 4'd8;
  localparam logic [3:0] SP_MAG_SML = 4'd9;
  localparam logic [3:0] SP_SCL_D   = 4'd10;
  localparam logic [3:0] SP_SCL_Q   = 4'd11;
  localparam logic [3:0] SP_KDT     = 4'd12;
  localparam logic [3:0] SP_INT_D   = 4'd13;
  localparam logic [3:0] SP_INT_Q   = 4'd14;

  function automatic logic signed [31:0] sat_w(input logic signed [67:0] v);
    logic signed [67:0] hi;
    logic signed [67:0] lo;
    hi = (68'sd1 <<< (SAT_BITS - 1)) - 68'sd1;
    lo = -hi - 68'sd1;
    if (v > hi) return hi[31:0];
    if (v < lo) return lo[31:0];
    return v[31:0];
  endfunction

  function automatic logic signed [67:0] sx(input logic signed [31:0] v);
    return 68'(v);
  endfunction

  // configuration registers
  logic [30:0]        kp_r, ki_r, lim_r, v2m_r, ld_r, lq_r;
  logic signed [31:0] flux_r;
  logic               ffen_r;

  // per-word working registers
  logic [2:0]         state_r;
  logic [3:0]         step_r;
  logic [31:0]        dt_r;
  logic signed [31:0] id_r, iq_r, we_r, ed_r, eq_r, t_r, f_r;
  logic signed [31:0] udff_r, uqff_r, udraw_r, uqraw_r, ud_r, uq_r, k_r;
  logic signed [31:0] dint_r, qint_r;
  logic [47:0]        pbig_r;
  logic [32:0]        mag_r;
  logic               lmt_r;

  // serial multiplier
  logic [65:0]        mul_a_r, mul_acc_r;
  logic [32:0]        mul_b_r;
  logic               mul_neg_r;
  logic [4:0]         mul_cnt_r;

  // serial divider
  logic [61:0]        num_r;
  logic [32:0]        rem_r;
  logic [31:0]        quo_r;
  logic [5:0]         div_cnt_r;

  logic               out_valid_r;
  out_word_t          out_data_r;

  // apb port
  wire cfg_wr = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_pready = 1'b1;

  always_comb begin
    case (cfg_paddr[4:2])
      REG_PROP_GAIN:   cfg_prdata = {1'b0, kp_r};
      REG_INTEG_GAIN:  cfg_prdata = {1'b0, ki_r};
      REG_VOLT_LIMIT:  cfg_prdata = {1'b0, lim_r};
      REG_VOLT_TO_MOD: cfg_prdata = {1'b0, v2m_r};
      REG_D_INDUCT:    cfg_prdata = {1'b0, ld_r};
      REG_Q_INDUCT:    cfg_prdata = {1'b0, lq_r};
      REG_ROTOR_FLUX:  cfg_prdata = flux_r;
      REG_FF_ENABLE:   cfg_prdata = {31'd0, ffen_r};
      default:         cfg_prdata = 32'd0;
    endcase
  end

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // absolute values of the raw vector for the magnitude estimate
  logic signed [32:0] ax, ay, mx, mn;
  always_comb begin
    ax = udraw_r[31] ? -33'(udraw_r) : 33'(udraw_r);
    ay = uqraw_r[31] ? -33'(uqraw_r) : 33'(uqraw_r);
    mx = (ax > ay) ? ax : ay;
    mn = (ax > ay) ? ay : ax;
  end

  // multiplier operand select
  logic signed [32:0] opa, opb;
  always_comb begin
    case (step_r)
      SP_FF_WLQ:  begin opa = 33'(we_r);    opb = {2'b0, lq_r};  end
      SP_FF_TIQ:  begin opa = 33'(t_r);     opb = 33'(iq_r);     end
      SP_FF_DV:   begin opa = 33'(t_r);     opb = {2'b0, v2m_r}; end
      SP_FF_LDID: begin opa = {2'b0, ld_r}; opb = 33'(id_r);     end
      SP_FF_WF:   begin opa = 33'(we_r);    opb = 33'(f_r);      end
      SP_FF_QV:   begin opa = 33'(t_r);     opb = {2'b0, v2m_r}; end
      SP_PI_D:    begin opa = {2'b0, kp_r}; opb = 33'(ed_r);     end
      SP_PI_Q:    begin opa = {2'b0, kp_r}; opb = 33'(eq_r);     end
      SP_MAG_BIG: begin opa = mx;           opb = {17'd0, MAG_BIG};   end
      SP_MAG_SML: begin opa = mn;           opb = {17'd0, MAG_SMALL}; end
      SP_SCL_D:   begin opa = ax;           opb = {2'b0, lim_r}; end
      SP_SCL_Q:   begin opa = ay;           opb = {2'b0, lim_r}; end
      SP_KDT:     begin opa = {2'b0, ki_r}; opb = {1'b0, dt_r};  end
      SP_INT_D:   begin opa = 33'(k_r);     opb = 33'(ed_r);     end
      SP_INT_Q:   begin opa = 33'(k_r);     opb = 33'(eq_r);     end
      default:    begin opa = '0;           opb = '0;            end
    endcase
  end

  // signed product, floor shift to the target format
  logic signed [65:0] prod_s, prod_sh;
  logic signed [31:0] ps;
  always_comb begin
    prod_s = mul_neg_r ? -$signed(mul_acc_r) : $signed(mul_acc_r);
    case (step_r)
      SP_FF_WLQ, SP_FF_WF: prod_sh = prod_s >>> 28;
      SP_KDT:              prod_sh = prod_s >>> 32;
      default:             prod_sh = prod_s >>> 16;
    endcase
    ps = sat_w(68'(prod_sh));
  end

  // radix-4 multiplier digit
  logic [65:0] mul_acc_nxt;
  assign mul_acc_nxt = mul_acc_r + (mul_b_r[0] ? mul_a_r : 66'd0)
                     + (mul_b_r[1] ? {mul_a_r[64:0], 1'b0} : 66'd0);

  // restoring divider digit
  logic [33:0] trial;
  logic        ge;
  logic [31:0] quo_nxt;
  always_comb begin
    trial   = {rem_r, num_r[61]};
    ge      = trial >= {1'b0, mag_r};
    quo_nxt = {quo_r[30:0], ge};
  end

  // magnitude from the two partial products
  logic [48:0] mag_sum;
  assign mag_sum = {1'b0, pbig_r} + {1'b0, mul_acc_r[47:0]};

  // integrator update for the current axis
  logic signed [31:0] e_sel, raw_sel, int_sel, int_sum, int_new;
  logic signed [32:0] lim_s;
  logic               int_en;
  always_comb begin
    e_sel   = (step_r == SP_INT_D) ? ed_r : eq_r;
    raw_sel = (step_r == SP_INT_D) ? udraw_r : uqraw_r;
    int_sel = (step_r == SP_INT_D) ? dint_r : qint_r;
    lim_s   = {2'b0, lim_r};
    int_sum = sat_w(sx(int_sel) + sx(ps));
    if (33'(int_sum) > lim_s) int_new = lim_s[31:0];
    else if (33'(int_sum) < -lim_s) int_new = 32'(-lim_s);
    else int_new = int_sum;
    int_en  = !lmt_r || (e_sel < 0 && raw_sel > 0) || (e_sel > 0 && raw_sel < 0);
  end

  logic out_fire;
  assign out_fire = (state_r == ST_POST) && (step_r == SP_INT_Q)
                    && (!out_valid_r || out_ch.ready);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r   <= '0;
      ki_r   <= '0;
      lim_r  <= LIMIT_RESET;
      v2m_r  <= '0;
      ld_r   <= '0;
      lq_r   <= '0;
      flux_r <= '0;
      ffen_r <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        REG_PROP_GAIN:   kp_r   <= cfg_pwdata[30:0];
        REG_INTEG_GAIN:  ki_r   <= cfg_pwdata[30:0];
        REG_VOLT_LIMIT:  lim_r  <= cfg_pwdata[30:0];
        REG_VOLT_TO_MOD: v2m_r  <= cfg_pwdata[30:0];
        REG_D_INDUCT:    ld_r   <= cfg_pwdata[30:0];
        REG_Q_INDUCT:    lq_r   <= cfg_pwdata[30:0];
        REG_ROTOR_FLUX:  flux_r <= cfg_pwdata;
        REG_FF_ENABLE:   ffen_r <= cfg_pwdata[0];
        default:         ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      out_data_r.d_volt  <= ud_r;
      out_data_r.q_volt  <= uq_r;
      out_data_r.limited <= lmt_r;
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= SP_PI_D;
      dint_r  <= '0;
      qint_r  <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            dt_r    <= in_ch.data.time_step;
            id_r    <= in_ch.data.d_meas;
            iq_r    <= in_ch.data.q_meas;
            we_r    <= in_ch.data.elec_speed;
            ed_r    <= sat_w(sx(in_ch.data.d_ref) - sx(in_ch.data.d_meas));
            eq_r    <= sat_w(sx(in_ch.data.q_ref) - sx(in_ch.data.q_meas));
            udff_r  <= '0;
            uqff_r  <= '0;
            if (in_ch.data.clear_integ) begin
              dint_r <= '0;
              qint_r <= '0;
            end
            step_r  <= ffen_r ? SP_FF_WLQ : SP_PI_D;
            state_r <= ST_START;
          end
        end
        ST_START: begin
          mul_a_r   <= {33'd0, (opa[32] ? -opa : opa)};
          mul_b_r   <= opb[32] ? -opb : opb;
          mul_neg_r <= opa[32] ^ opb[32];
          mul_acc_r <= '0;
          mul_cnt_r <= '0;
          state_r   <= ST_MUL;
        end
        ST_MUL: begin
          mul_acc_r <= mul_acc_nxt;
          mul_a_r   <= {mul_a_r[63:0], 2'b00};
          mul_b_r   <= {2'b00, mul_b_r[32:2]};
          mul_cnt_r <= mul_cnt_r + 5'd1;
          if (mul_cnt_r == 5'd16) state_r <= ST_POST;
        end
        ST_POST: begin
          state_r <= ST_START;
          step_r  <= step_r + 4'd1;
          case (step_r)
            SP_FF_WLQ, SP_FF_TIQ, SP_FF_WF: t_r <= ps;
            SP_FF_DV:   udff_r <= sat_w(-sx(ps));
            SP_FF_LDID: f_r    <= sat_w(sx(ps) + sx(flux_r));
            SP_FF_QV:   uqff_r <= ps;
            SP_PI_D:    udraw_r <= sat_w(sx(sat_w(sx(ps) + sx(dint_r))) + sx(udff_r));
            SP_PI_Q:    uqraw_r <= sat_w(sx(sat_w(sx(ps) + sx(qint_r))) + sx(uqff_r));
            SP_MAG_BIG: pbig_r  <= mul_acc_r[47:0];
            SP_MAG_SML: begin
              mag_r <= mag_sum[48:16];
              if (mag_sum[48:16] > {2'b0, lim_r}) begin
                lmt_r <= 1'b1;
              end else begin
                lmt_r  <= 1'b0;
                ud_r   <= udraw_r;
                uq_r   <= uqraw_r;
                step_r <= SP_KDT;
              end
            end
            SP_SCL_D, SP_SCL_Q: begin
              num_r     <= mul_acc_r[61:0];
              rem_r     <= '0;
              quo_r     <= '0;
              div_cnt_r <= '0;
              step_r    <= step_r;
              state_r   <= ST_DIV;
            end
            SP_KDT:     k_r <= ps;
            SP_INT_D: begin
              if (int_en) dint_r <= int_new;
            end
            SP_INT_Q: begin
              if (out_fire) begin
                if (int_en) qint_r <= int_new;
                state_r <= ST_IDLE;
              end else begin
                step_r  <= step_r;
                state_r <= ST_POST;
              end
            end
            default: ;
          endcase
        end
        ST_DIV: begin
          num_r     <= {num_r[60:0], 1'b0};
          rem_r     <= ge ? 33'(trial - {1'b0, mag_r}) : trial[32:0];
          quo_r     <= quo_nxt;
          div_cnt_r <= div_cnt_r + 6'd1;
          if (div_cnt_r == 6'd61) begin
            if (step_r == SP_SCL_D) ud_r <= udraw_r[31] ? -quo_nxt : quo_nxt;
            else uq_r <= uqraw_r[31] ? -quo_nxt : quo_nxt;
            step_r  <= step_r + 4'd1;
            state_r <= ST_START;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
